@@ rtl/core/ecd_pkg.sv @@
package ecd_pkg;

    // Field widths of the request and result.
    localparam int unsigned SECS_W   = 32;
    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned DAYS_W   = 16;

    // Pipeline depth; stages 2 through 7 belong to the date path.
    localparam int unsigned NUM_STAGES = 8;
    localparam int unsigned DATE_STAGES = 6;

    localparam int unsigned DAYS_SHIFT   = 719468;
    localparam int unsigned DAYS_PER_ERA = 146097;
    localparam int unsigned ERA4_START   = 4 * DAYS_PER_ERA;
    localparam int unsigned ERA5_START   = 5 * DAYS_PER_ERA;
    localparam int unsigned LAST_DOE     = 146096;
    localparam int unsigned CENT_DAYS    = 36524;

    // Reciprocals rounded up; each is exact over the operand range it sees.
    localparam int unsigned RECIP_675   = 50903317;  // x < 2^25, shift 35
    localparam int unsigned RECIP_365_A = 91930;     // x <= 36524, shift 25
    localparam int unsigned RECIP_365_B = 367720;    // x <= 146096, shift 27
    localparam int unsigned RECIP_153   = 3427;      // x <= 1827, shift 19
    localparam int unsigned RECIP_3600  = 149131;    // x < 86400, shift 29
    localparam int unsigned RECIP_60    = 4370;      // x < 3600, shift 18

    typedef logic [DATE_STAGES-1:0] date_en_t;

    // Days from March 1 to the first day of the shifted month index.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] res;
        begin
            unique case (mp)
                4'd0:    res = 9'd0;
                4'd1:    res = 9'd31;
                4'd2:    res = 9'd61;
                4'd3:    res = 9'd92;
                4'd4:    res = 9'd122;
                4'd5:    res = 9'd153;
                4'd6:    res = 9'd184;
                4'd7:    res = 9'd214;
                4'd8:    res = 9'd245;
                4'd9:    res = 9'd275;
                4'd10:   res = 9'd306;
                4'd11:   res = 9'd337;
                default: res = 9'd0;
            endcase
            return res;
        end
    endfunction

endpackage

@@ rtl/core/ecd_date.sv @@
module ecd_date (
    input  logic                          clk,
    input  ecd_pkg::date_en_t             en,
    input  logic [ecd_pkg::DAYS_W-1:0]    days,
    output logic [ecd_pkg::YEAR_W-1:0]    year,
    output logic [ecd_pkg::MONTH_W-1:0]   month,
    output logic [ecd_pkg::DAY_W-1:0]     day
);
    import ecd_pkg::*;

    logic [17:0] doe_s2_reg, doe_s2_next;
    logic        era_s2_reg, era_s2_next;
    logic [19:0] z;

    logic [32:0] p1_s3_reg, p1_s3_next;
    logic [17:0] doe_s3_reg;
    logic        era_s3_reg;

    logic [7:0]  q1460;
    logic [2:0]  q36524;
    logic        q146096;
    logic [17:0] n;
    logic [35:0] p2_s4_reg, p2_s4_next;
    logic [17:0] doe_s4_reg;
    logic        era_s4_reg;

    logic [8:0]  yoe;
    logic [1:0]  yoe_q100;
    logic [17:0] yr_days;
    logic [8:0]  doy_s5_reg, doy_s5_next;
    logic [8:0]  yoe_s5_reg;
    logic        era_s5_reg;

    logic [10:0] mp_num;
    logic [22:0] p3_s6_reg, p3_s6_next;
    logic [8:0]  doy_s6_reg;
    logic [8:0]  yoe_s6_reg;
    logic        era_s6_reg;

    logic [3:0]  mp;
    logic [3:0]  month_next;
    logic [4:0]  day_next;
    logic [11:0] year_next;
    logic [11:0] year_s7_reg;
    logic [3:0]  month_s7_reg;
    logic [4:0]  day_s7_reg;

    // Shift to a March-based count from year 0 and find the 400-year era.
    always_comb
    begin
        z           = 20'(days) + 20'(DAYS_SHIFT);
        era_s2_next = (z >= 20'(ERA5_START));
        doe_s2_next = 18'(z - (era_s2_next ? 20'(ERA5_START) : 20'(ERA4_START)));
    end

    assign p1_s3_next = 33'(doe_s2_reg[17:2]) * 33'(RECIP_365_A);

    // Year of era: correct the day count for leap days, then divide by 365.
    always_comb
    begin
        q1460   = p1_s3_reg[32:25];
        q146096 = (doe_s3_reg == 18'(LAST_DOE));
        if (doe_s3_reg >= 18'(4 * CENT_DAYS))
        begin
            q36524 = 3'd4;
        end
        else if (doe_s3_reg >= 18'(3 * CENT_DAYS))
        begin
            q36524 = 3'd3;
        end
        else if (doe_s3_reg >= 18'(2 * CENT_DAYS))
        begin
            q36524 = 3'd2;
        end
        else if (doe_s3_reg >= 18'(CENT_DAYS))
        begin
            q36524 = 3'd1;
        end
        else
        begin
            q36524 = 3'd0;
        end
        n          = doe_s3_reg - 18'(q1460) + 18'(q36524) - 18'(q146096);
        p2_s4_next = 36'(n) * 36'(RECIP_365_B);
    end

    always_comb
    begin
        yoe = p2_s4_reg[35:27];
        if (yoe >= 9'd300)
        begin
            yoe_q100 = 2'd3;
        end
        else if (yoe >= 9'd200)
        begin
            yoe_q100 = 2'd2;
        end
        else if (yoe >= 9'd100)
        begin
            yoe_q100 = 2'd1;
        end
        else
        begin
            yoe_q100 = 2'd0;
        end
        yr_days     = 18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(yoe_q100);
        doy_s5_next = 9'(doe_s4_reg - yr_days);
    end

    always_comb
    begin
        mp_num     = 11'(doy_s5_reg) * 11'd5 + 11'd2;
        p3_s6_next = 23'(mp_num) * 23'(RECIP_153);
    end

    // Month index counts from March, so January and February close the year.
    always_comb
    begin
        mp         = p3_s6_reg[22:19];
        day_next   = 5'(doy_s6_reg - month_start(mp) + 9'd1);
        month_next = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
        year_next  = 12'(yoe_s6_reg) + (era_s6_reg ? 12'd2000 : 12'd1600)
                   + ((month_next <= 4'd2) ? 12'd1 : 12'd0);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            doe_s2_reg <= doe_s2_next;
            era_s2_reg <= era_s2_next;
        end
        if (en[1])
        begin
            p1_s3_reg  <= p1_s3_next;
            doe_s3_reg <= doe_s2_reg;
            era_s3_reg <= era_s2_reg;
        end
        if (en[2])
        begin
            p2_s4_reg  <= p2_s4_next;
            doe_s4_reg <= doe_s3_reg;
            era_s4_reg <= era_s3_reg;
        end
        if (en[3])
        begin
            doy_s5_reg <= doy_s5_next;
            yoe_s5_reg <= yoe;
            era_s5_reg <= era_s4_reg;
        end
        if (en[4])
        begin
            p3_s6_reg  <= p3_s6_next;
            doy_s6_reg <= doy_s5_reg;
            yoe_s6_reg <= yoe_s5_reg;
            era_s6_reg <= era_s5_reg;
        end
        if (en[5])
        begin
            year_s7_reg  <= year_next;
            month_s7_reg <= month_next;
            day_s7_reg   <= day_next;
        end
    end

    assign year  = year_s7_reg;
    assign month = month_s7_reg;
    assign day   = day_s7_reg;

endmodule

@@ rtl/core/epoch_seconds_to_civil_datetime.sv @@
// Throughput: one request per cycle while the output is not stalled; each of
// the eight stages holds one item and loads whenever the stage after it is
// free or being emptied.
// The clock rate is set by the longest stage.
// Reset clears only the stage valid bits; the datapath registers are not reset.
module epoch_seconds_to_civil_datetime (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ecd_pkg::SECS_W-1:0]      epoch_seconds,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ecd_pkg::YEAR_W-1:0]      year,
    output logic [ecd_pkg::MONTH_W-1:0]     month,
    output logic [ecd_pkg::DAY_W-1:0]       day,
    output logic [ecd_pkg::HOUR_W-1:0]      hour,
    output logic [ecd_pkg::MINUTE_W-1:0]    minute,
    output logic [ecd_pkg::SECOND_W-1:0]    second
);
    import ecd_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] rdy;

    logic [50:0] p0_s0_reg, p0_s0_next;
    logic [24:0] q0_s0_reg;
    logic [6:0]  lo_s0_reg;

    logic [15:0] days_next;
    logic [9:0]  rem_next;
    logic [15:0] days_s1_reg;
    logic [16:0] sod_s1_reg;

    logic [33:0] ph_s2_reg, ph_s2_next;
    logic [16:0] sod_s2_reg;

    logic [4:0]  hour_next;
    logic [11:0] r_s3_next;
    logic [11:0] r_s3_reg;
    logic [4:0]  hour_s3_reg, hour_s4_reg, hour_s5_reg, hour_s6_reg, hour_s7_reg;

    logic [23:0] pm_s4_reg, pm_s4_next;
    logic [11:0] r_s4_reg;

    logic [5:0]  min_next;
    logic [5:0]  sec_next;
    logic [5:0]  min_s5_reg, min_s6_reg, min_s7_reg;
    logic [5:0]  sec_s5_reg, sec_s6_reg, sec_s7_reg;

    // A stage may load when it is empty or the stage after it takes its item.
    always_comb
    begin
        rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = vld_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // 86400 = 128 * 675: the low seven bits pass straight into the seconds of day.
    assign p0_s0_next = 51'(epoch_seconds[31:7]) * 51'(RECIP_675);

    always_comb
    begin
        days_next = p0_s0_reg[50:35];
        rem_next  = 10'(q0_s0_reg - 25'(days_next) * 25'd675);
    end

    assign ph_s2_next = 34'(sod_s1_reg) * 34'(RECIP_3600);

    always_comb
    begin
        hour_next = ph_s2_reg[33:29];
        r_s3_next = 12'(sod_s2_reg - 17'(hour_next) * 17'd3600);
    end

    assign pm_s4_next = 24'(r_s3_reg) * 24'(RECIP_60);

    always_comb
    begin
        min_next = pm_s4_reg[23:18];
        sec_next = 6'(r_s4_reg - 12'(min_next) * 12'd60);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            p0_s0_reg <= p0_s0_next;
            q0_s0_reg <= epoch_seconds[31:7];
            lo_s0_reg <= epoch_seconds[6:0];
        end
        if (rdy[1])
        begin
            days_s1_reg <= days_next;
            sod_s1_reg  <= {rem_next, lo_s0_reg};
        end
        if (rdy[2])
        begin
            ph_s2_reg  <= ph_s2_next;
            sod_s2_reg <= sod_s1_reg;
        end
        if (rdy[3])
        begin
            r_s3_reg    <= r_s3_next;
            hour_s3_reg <= hour_next;
        end
        if (rdy[4])
        begin
            pm_s4_reg   <= pm_s4_next;
            r_s4_reg    <= r_s3_reg;
            hour_s4_reg <= hour_s3_reg;
        end
        if (rdy[5])
        begin
            min_s5_reg  <= min_next;
            sec_s5_reg  <= sec_next;
            hour_s5_reg <= hour_s4_reg;
        end
        if (rdy[6])
        begin
            min_s6_reg  <= min_s5_reg;
            sec_s6_reg  <= sec_s5_reg;
            hour_s6_reg <= hour_s5_reg;
        end
        if (rdy[7])
        begin
            min_s7_reg  <= min_s6_reg;
            sec_s7_reg  <= sec_s6_reg;
            hour_s7_reg <= hour_s6_reg;
        end
    end

    ecd_date u_date (
        .clk   (clk),
        .en    (date_en_t'(rdy[NUM_STAGES-1:2])),
        .days  (days_s1_reg),
        .year  (year),
        .month (month),
        .day   (day)
    );

    assign hour   = hour_s7_reg;
    assign minute = min_s7_reg;
    assign second = sec_s7_reg;

    // An empty output stage means the whole chain can move.
    a_empty_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[NUM_STAGES-1] |-> !in_stall)
        else $error("input stalled while the output stage is empty");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month >= 4'd1) && (month <= 4'd12) && (day >= 5'd1)
                      && (year >= 12'd1970) && (year <= 12'd2106))
        else $error("calendar date out of range");

endmodule
